FILE: src/u2u8_pkg.sv
// shared types and constants for the utf-16 to utf-8 transcoder
package u2u8_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MaxLen = 4;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned CntW   = 3;
  localparam int unsigned HalfW  = 10;

  localparam logic [ByteW-1:0] LeadTwo   = 8'hC0;
  localparam logic [ByteW-1:0] LeadThree = 8'hE0;
  localparam logic [ByteW-1:0] LeadFour  = 8'hF0;
  localparam logic [ByteW-1:0] ContMark  = 8'h80;
  localparam logic [5:0]       HighSurrTag = 6'b110110;

  // encoded sequence for one item, lead byte in slot 0
  typedef struct packed {
    logic [MaxLen-1:0][ByteW-1:0] seq;
    logic [CntW-1:0]              count;
  } enc_t;

endpackage

FILE: src/u2u8_enc.sv
// code unit encoder with surrogate pairing state
module u2u8_enc import u2u8_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [UnitW-1:0] code_unit_i,
  output enc_t             enc_o
);

  logic             pending_q, pending_d;
  logic [HalfW-1:0] high_q, high_d;
  logic [20:0]      cp;
  logic             is_high;

  assign cp      = {1'b0, high_q, code_unit_i[HalfW-1:0]} + 21'h10000;
  assign is_high = (code_unit_i[15:10] == HighSurrTag);

  always_comb begin
    enc_o     = '0;
    pending_d = pending_q;
    high_d    = high_q;
    if (pending_q) begin
      enc_o.seq[0] = LeadFour | {5'd0, cp[20:18]};
      enc_o.seq[1] = ContMark | {2'd0, cp[17:12]};
      enc_o.seq[2] = ContMark | {2'd0, cp[11:6]};
      enc_o.seq[3] = ContMark | {2'd0, cp[5:0]};
      enc_o.count  = CntW'(4);
      pending_d    = 1'b0;
      high_d       = '0;
    end else if (code_unit_i[15:7] == '0) begin
      enc_o.seq[0] = code_unit_i[7:0];
      enc_o.count  = CntW'(1);
    end else if (code_unit_i[15:11] == '0) begin
      enc_o.seq[0] = LeadTwo | {3'd0, code_unit_i[10:6]};
      enc_o.seq[1] = ContMark | {2'd0, code_unit_i[5:0]};
      enc_o.count  = CntW'(2);
    end else if (is_high) begin
      // held until the low half arrives, nothing emitted
      pending_d = 1'b1;
      high_d    = code_unit_i[HalfW-1:0];
    end else begin
      enc_o.seq[0] = LeadThree | {4'd0, code_unit_i[15:12]};
      enc_o.seq[1] = ContMark | {2'd0, code_unit_i[11:6]};
      enc_o.seq[2] = ContMark | {2'd0, code_unit_i[5:0]};
      enc_o.count  = CntW'(3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      high_q    <= '0;
    end else if (accept_i) begin
      pending_q <= pending_d;
      high_q    <= high_d;
    end
  end

endmodule

FILE: src/u2u8_ser.sv
// result register and byte serialiser
module u2u8_ser import u2u8_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  enc_t             enc_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             last_byte_o
);

  logic [MaxLen-1:0][ByteW-1:0] seq_q;
  logic                         full_q;
  logic [IdxW-1:0]              idx_q, last_q;
  logic                         pop, at_last;

  assign at_last     = (idx_q == last_q);
  assign pop         = full_q && !out_stall_i;
  assign free_o      = !full_q || (pop && at_last);
  assign out_valid_o = full_q;
  assign out_byte_o  = seq_q[idx_q];
  assign last_byte_o = at_last;

  always_ff @(posedge clk_i) begin
    if (load_i && enc_i.count != '0) begin
      seq_q <= enc_i.seq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      idx_q  <= '0;
      last_q <= '0;
    end else if (load_i && enc_i.count != '0) begin
      full_q <= 1'b1;
      idx_q  <= '0;
      last_q <= IdxW'(enc_i.count - CntW'(1));
    end else if (pop) begin
      if (at_last) begin
        full_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> idx_q <= last_q) else $error("byte index past end of sequence");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !at_last) |=> full_q && idx_q == $past(idx_q) + IdxW'(1))
    else $error("serialiser did not advance by one byte");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q && out_stall_i) |=> full_q && $stable(idx_q) && $stable(last_q))
    else $error("stalled sequence moved");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o) else $error("item loaded while sequence still draining");

endmodule

FILE: src/utf16_to_utf8_transcoder.sv
// top level of the utf-16 to utf-8 transcoder
// Takes one UTF-16 code unit per item and delivers its UTF-8 bytes one per
// output item, lead byte first, with last_byte_o high on the final byte of
// each code point. A high surrogate produces no output and is paired with
// the next unit, of which only the low ten bits are used; a lone low
// surrogate is encoded as an ordinary three-byte unit. Encoding is done in
// the same cycle the unit is accepted and the bytes go into a result
// register that drains through the single byte-wide output port, so a unit
// holds the output until each of its bytes is taken: one item per cycle for
// ascii text and high surrogates if unstalled, one item per byte for longer
// sequences. A new unit is accepted in the cycle the final byte of the
// previous sequence is taken, so there is no bubble between sequences.
// No configuration, no start-up pass after reset.
module utf16_to_utf8_transcoder import u2u8_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [UnitW-1:0] code_unit_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             last_byte_o
);

  logic accept;
  logic free;
  enc_t enc;

  // take an item only when the result register is empty or emptying now
  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  // encoder: surrogate pairing state plus byte layout
  u2u8_enc u_enc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .code_unit_i (code_unit_i),
    .enc_o       (enc)
  );

  // result register, one byte per output item
  u2u8_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .enc_i       (enc),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

FILE: tb/utf16_to_utf8_transcoder_tb.sv
// self-checking testbench for the utf-16 to utf-8 transcoder
module utf16_to_utf8_transcoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u2u8_pkg::*;

  // upper six bits of a low surrogate, next to the package's high surrogate tag
  localparam logic [5:0] LowSurrTag    = 6'b110111;
  localparam int         NumDirected   = 25;
  localparam int         NumRandom     = 125;
  // long receiver hold-off, so the result register fills and the input stalls
  localparam int         HoldOffCycles = 60;
  // one four-byte sequence plus margin after the last awaited byte
  localparam int         TailCycles    = 12;
  localparam int         DrainLimit    = 4000;
  localparam int         SeqW          = MaxLen * ByteW;

  // one expected output item
  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             last;
  } utf8_byte_t;

  // directed stimulus row; seq holds the lead byte in its top byte
  typedef struct {
    logic [UnitW-1:0] unit;
    bit               typed;
    int               count;
    logic [SeqW-1:0]  seq;
  } unit_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [UnitW-1:0] code_unit_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ByteW-1:0] out_byte_o;
  logic             last_byte_o;

  // predictor state: a held high surrogate and its ten payload bits
  logic             pair_open = 1'b0;
  logic [HalfW-1:0] high_bits = '0;

  utf8_byte_t       awaited_bytes[$];
  utf8_byte_t       oldest_byte;
  int               fail_count = 0;
  // idling phase: 0 sender light / receiver heavy, 1 swapped, 2 no idling
  int               stage = 0;

  always #5 clk_i = ~clk_i;

  utf16_to_utf8_transcoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .code_unit_i (code_unit_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

  // directed table: extremes, each length class, lone low surrogates, proper
  // pairs and the odd cases where anything at all follows a high surrogate;
  // typed rows carry their bytes, the rest go through the predictor
  unit_row_t directed_rows [NumDirected] = '{
    '{16'h0000, 1'b1, 1, 32'h0000_0000},  // zero unit gives a single 00
    '{16'h007F, 1'b1, 1, 32'h7F00_0000},  // top of the one-byte range
    '{16'h0080, 1'b1, 2, 32'hC280_0000},  // bottom of the two-byte range
    '{16'h07FF, 1'b1, 2, 32'hDFBF_0000},  // top of the two-byte range
    '{16'h0800, 1'b1, 3, 32'hE0A0_8000},  // bottom of the three-byte range
    '{16'hFFFF, 1'b1, 3, 32'hEFBF_BF00},  // all ones
    '{16'hDC00, 1'b1, 3, 32'hEDB0_8000},  // lone low surrogate, plain encoding
    '{16'hDFFF, 1'b0, 0, '0},             // lone low surrogate, top end
    '{16'hD800, 1'b1, 0, '0},             // high surrogate gives nothing
    '{16'hDC00, 1'b1, 4, 32'hF090_8080},  // smallest supplementary point
    '{16'hDBFF, 1'b1, 0, '0},
    '{16'hDFFF, 1'b1, 4, 32'hF48F_BFBF},  // largest supplementary point
    '{16'hD800, 1'b0, 0, '0},
    '{16'hD800, 1'b0, 0, '0},             // second high surrogate taken as low half
    '{16'hDBFF, 1'b0, 0, '0},
    '{16'h0000, 1'b0, 0, '0},             // zero taken as low half
    '{16'hD955, 1'b0, 0, '0},
    '{16'h0041, 1'b0, 0, '0},             // ascii taken as low half
    '{16'hD800, 1'b0, 0, '0},
    '{16'hFFFF, 1'b0, 0, '0},             // all ones taken as low half
    '{16'hAAAA, 1'b0, 0, '0},
    '{16'h5555, 1'b0, 0, '0},
    '{16'h0001, 1'b0, 0, '0},
    '{16'h0100, 1'b0, 0, '0},
    '{16'hE000, 1'b0, 0, '0}              // first unit above the surrogates
  };

  // encodes one accepted unit, updating the held surrogate state
  task automatic predict_unit(input logic [UnitW-1:0] u, output int n,
                              output logic [SeqW-1:0] seq);
    logic [20:0] point;
    seq = '0;
    n   = 0;
    if (pair_open) begin
      // anything after a high surrogate closes the pair with its low ten bits
      point     = 21'h10000 + {1'b0, high_bits, u[HalfW-1:0]};
      pair_open = 1'b0;
      high_bits = '0;
      seq = {LeadFour | {5'b0, point[20:18]}, ContMark | {2'b0, point[17:12]},
             ContMark | {2'b0, point[11:6]},  ContMark | {2'b0, point[5:0]}};
      n   = 4;
    end else if (u[15:7] == '0) begin
      seq = {u[7:0], 24'h0};
      n   = 1;
    end else if (u[15:11] == '0) begin
      seq = {LeadTwo | {3'b0, u[10:6]}, ContMark | {2'b0, u[5:0]}, 16'h0};
      n   = 2;
    end else if (u[15:10] == HighSurrTag) begin
      pair_open = 1'b1;
      high_bits = u[HalfW-1:0];
    end else begin
      seq = {LeadThree | {4'b0, u[15:12]}, ContMark | {2'b0, u[11:6]},
             ContMark | {2'b0, u[5:0]}, 8'h0};
      n   = 3;
    end
  endtask

  function automatic int idle_pct(input bit sender);
    case (stage)
      0:       return sender ? 18 : 48;
      1:       return sender ? 48 : 18;
      default: return 0;
    endcase
  endfunction

  // offers one unit from a falling edge and waits for the handshake; the
  // expected bytes are queued at the accepting edge
  task automatic send_unit(input logic [UnitW-1:0] u, input bit typed,
                           input int typed_n, input logic [SeqW-1:0] typed_seq);
    int              n;
    logic [SeqW-1:0] seq;
    while ($urandom_range(99) < idle_pct(1'b1)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    code_unit_i <= u;
    do @(posedge clk_i); while (in_stall_o);
    predict_unit(u, n, seq);
    if (typed) begin
      n   = typed_n;
      seq = typed_seq;
    end
    for (int i = 0; i < n; i++) begin
      awaited_bytes.push_back('{seq[SeqW-1-i*ByteW -: ByteW], i == n - 1});
    end
    @(negedge clk_i);
  endtask

  // receiver: random stall by phase, plus one long hold-off once the
  // no-idling phase starts, while the sender keeps offering units
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stage == 2 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < idle_pct(1'b0));
      end
    end
  end

  // checks each accepted byte against the oldest awaited one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_bytes.size() == 0) begin
        $error("unexpected item: out_byte %h last_byte %b", out_byte_o, last_byte_o);
        fail_count++;
      end else begin
        oldest_byte = awaited_bytes.pop_front();
        if (out_byte_o !== oldest_byte.value) begin
          $error("out_byte: expected %h, actual %h", oldest_byte.value, out_byte_o);
          fail_count++;
        end
        if (last_byte_o !== oldest_byte.last) begin
          $error("last_byte: expected %b, actual %b", oldest_byte.last, last_byte_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [UnitW-1:0] random_units[$];
    int               total;
    int               pick;
    int               waited;
    // random text: mostly well-formed units and surrogate pairs, with some
    // lone low surrogates and high surrogates followed by anything
    while (random_units.size() < NumRandom) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        random_units.push_back(16'($urandom_range(16'h007F, 16'h0000)));
      end else if (pick < 40) begin
        random_units.push_back(16'($urandom_range(16'h07FF, 16'h0080)));
      end else if (pick < 60) begin
        if ($urandom_range(1) == 0) begin
          random_units.push_back(16'($urandom_range(16'hD7FF, 16'h0800)));
        end else begin
          random_units.push_back(16'($urandom_range(16'hFFFF, 16'hE000)));
        end
      end else if (pick < 85) begin
        random_units.push_back({HighSurrTag, 10'($urandom)});
        random_units.push_back({LowSurrTag, 10'($urandom)});
      end else if (pick < 90) begin
        random_units.push_back({LowSurrTag, 10'($urandom)});
      end else begin
        random_units.push_back({HighSurrTag, 10'($urandom)});
        random_units.push_back(16'($urandom));
      end
    end
    total = NumDirected + random_units.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      stage = (i * 3) / total;
      send_unit(directed_rows[i].unit, directed_rows[i].typed,
                directed_rows[i].count, directed_rows[i].seq);
    end
    foreach (random_units[i]) begin
      stage = ((NumDirected + i) * 3) / total;
      send_unit(random_units[i], 1'b0, 0, '0);
    end
    in_valid_i <= 1'b0;

    // let the output drain, then watch a little longer for stray items
    waited = 0;
    while (awaited_bytes.size() > 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (awaited_bytes.size() > 0) begin
      $error("%0d awaited bytes never arrived", awaited_bytes.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hard limit, far beyond the slowest correct run
  initial begin : watchdog
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
src/u2u8_pkg.sv
src/u2u8_enc.sv
src/u2u8_ser.sv
src/utf16_to_utf8_transcoder.sv
tb/utf16_to_utf8_transcoder_tb.sv
